FILE: sv/itaf_pkg.sv
package itaf_pkg;

    // fixed field widths
    localparam int MAG_W         = 64;
    localparam int WIDTH_W       = 6;
    localparam int CHAR_W        = 8;
    localparam int NUM_DIG       = 20;
    localparam int DIG_W         = NUM_DIG * 4;
    localparam int DCNT_W        = 5;
    localparam int CONV_CNT_W    = 6;
    localparam int MAX_WIDTH_DEF = 63;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;

    typedef enum logic [1:0] {
        SEL_SPACE,
        SEL_MINUS,
        SEL_ZERO,
        SEL_DIGIT
    } char_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      norm_step;
        logic      pad_load;
        logic      pad_dec;
        logic      dig_step;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hex;
        logic neg;
        logic lead_space;
        logic lead_zero;
        logic trail_space;
        logic conv_last;
        logic norm_done;
        logic pad_zero;
        logic pad_one;
        logic dig_one;
        logic out_free;
    } dp_status_t;

    // one hex or decimal digit to its ascii code
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic up);
        logic [CHAR_W-1:0] base;
        base = up ? CH_UPPER : CH_LOWER;
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'b0, d};
        else
            digit_char = base + {4'b0, d - 4'd10};
    endfunction

endpackage

FILE: sv/itaf_ctrl.sv
module itaf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  itaf_pkg::dp_status_t st,
    output itaf_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_PAD,
        S_LEAD,
        S_SIGN,
        S_ZERO,
        S_DIG
    } state_t;

    // trailing spaces are handled by a separate flag kept beside the state register
    typedef enum logic {
        T_OFF,
        T_ON
    } trail_t;

    state_t state_reg, state_next;
    trail_t trail_reg, trail_next;

    assign in_stall = (state_reg != S_IDLE) || (trail_reg == T_ON);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        trail_next = trail_reg;
        cmd        = '0;
        cmd.sel    = itaf_pkg::SEL_SPACE;
        if (trail_reg == T_ON)
        begin
            // trailing spaces after the digits
            if (!(st.trail_space && !st.pad_zero))
                trail_next = T_OFF;
            else if (st.out_free)
            begin
                cmd.emit    = 1'b1;
                cmd.sel     = itaf_pkg::SEL_SPACE;
                cmd.last    = st.pad_one;
                cmd.pad_dec = 1'b1;
                if (st.pad_one)
                    trail_next = T_OFF;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CONV;
                    end
                end
                S_CONV:
                begin
                    if (st.hex)
                        state_next = S_NORM;
                    else
                    begin
                        cmd.conv_step = 1'b1;
                        if (st.conv_last)
                            state_next = S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (st.norm_done)
                        state_next = S_PAD;
                    else
                        cmd.norm_step = 1'b1;
                end
                S_PAD:
                begin
                    cmd.pad_load = 1'b1;
                    state_next   = S_LEAD;
                end
                S_LEAD:
                begin
                    if (!(st.lead_space && !st.pad_zero))
                        state_next = S_SIGN;
                    else if (st.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.sel     = itaf_pkg::SEL_SPACE;
                        cmd.pad_dec = 1'b1;
                        if (st.pad_one)
                            state_next = S_SIGN;
                    end
                end
                S_SIGN:
                begin
                    if (!st.neg)
                        state_next = S_ZERO;
                    else if (st.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.sel    = itaf_pkg::SEL_MINUS;
                        state_next = S_ZERO;
                    end
                end
                S_ZERO:
                begin
                    if (!(st.lead_zero && !st.pad_zero))
                        state_next = S_DIG;
                    else if (st.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.sel     = itaf_pkg::SEL_ZERO;
                        cmd.pad_dec = 1'b1;
                        if (st.pad_one)
                            state_next = S_DIG;
                    end
                end
                S_DIG:
                begin
                    if (st.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.sel      = itaf_pkg::SEL_DIGIT;
                        cmd.dig_step = 1'b1;
                        cmd.last     = st.dig_one && !(st.trail_space && !st.pad_zero);
                        if (st.dig_one)
                        begin
                            state_next = S_IDLE;
                            trail_next = T_ON;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            trail_reg <= T_OFF;
        end
        else
        begin
            state_reg <= state_next;
            trail_reg <= trail_next;
        end
    end

endmodule

FILE: sv/itaf_dp.sv
module itaf_dp #(
    parameter int MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [itaf_pkg::MAG_W-1:0]          magnitude,
    input  logic                                negative,
    input  logic                                hex_base,
    input  logic                                upper_case,
    input  logic [itaf_pkg::WIDTH_W-1:0]        min_width,
    input  logic                                zero_fill,
    input  logic                                left_align,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [itaf_pkg::CHAR_W-1:0]         out_char,
    output logic                                last_char,
    input  itaf_pkg::ctrl_cmd_t                 cmd,
    output itaf_pkg::dp_status_t                st
);

    localparam int PAD_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = 7;

    logic [itaf_pkg::MAG_W-1:0]      mag_reg;
    logic [itaf_pkg::DIG_W-1:0]      dig_reg;
    logic [itaf_pkg::DIG_W-1:0]      dig_adj;
    logic [itaf_pkg::CONV_CNT_W-1:0] conv_cnt_reg;
    logic [itaf_pkg::DCNT_W-1:0]     dig_cnt_reg;
    logic [PAD_W-1:0]                width_reg;
    logic [PAD_W-1:0]                pad_reg;
    logic                            neg_reg;
    logic                            hex_reg;
    logic                            up_reg;
    logic                            zf_reg;
    logic                            left_reg;
    logic [CMP_W-1:0]                w_ext;
    logic [CMP_W-1:0]                t_ext;
    logic [itaf_pkg::CHAR_W-1:0]     char_sel;
    logic                            out_valid_reg;
    logic [itaf_pkg::CHAR_W-1:0]     out_char_reg;
    logic                            last_reg;

    // add-3 correction on every bcd digit before the shift
    always_comb
    begin
        for (int i = 0; i < itaf_pkg::NUM_DIG; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            else
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
        end
    end

    // field width minus text length
    assign w_ext = CMP_W'(width_reg);
    assign t_ext = CMP_W'(dig_cnt_reg) + CMP_W'(neg_reg);

    // character for the word being sent
    always_comb
    begin
        case (cmd.sel)
            itaf_pkg::SEL_SPACE: char_sel = itaf_pkg::CH_SPACE;
            itaf_pkg::SEL_MINUS: char_sel = itaf_pkg::CH_MINUS;
            itaf_pkg::SEL_ZERO:  char_sel = itaf_pkg::CH_ZERO;
            default:
                char_sel = itaf_pkg::digit_char(dig_reg[itaf_pkg::DIG_W-1 -: 4], up_reg);
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg      <= magnitude;
            neg_reg      <= negative;
            hex_reg      <= hex_base;
            up_reg       <= upper_case;
            zf_reg       <= zero_fill;
            left_reg     <= left_align;
            conv_cnt_reg <= '0;
            dig_cnt_reg  <= itaf_pkg::DCNT_W'(itaf_pkg::NUM_DIG);
            if ({1'b0, min_width} > CMP_W'(MAX_WIDTH))
                width_reg <= PAD_W'(MAX_WIDTH);
            else
                width_reg <= PAD_W'(min_width);
            if (hex_base)
                dig_reg <= itaf_pkg::DIG_W'(magnitude);
            else
                dig_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            dig_reg      <= {dig_adj[itaf_pkg::DIG_W-2:0], mag_reg[itaf_pkg::MAG_W-1]};
            mag_reg      <= {mag_reg[itaf_pkg::MAG_W-2:0], 1'b0};
            conv_cnt_reg <= conv_cnt_reg + 1'b1;
        end
        else if (cmd.norm_step || cmd.dig_step)
        begin
            dig_reg     <= {dig_reg[itaf_pkg::DIG_W-5:0], 4'h0};
            dig_cnt_reg <= dig_cnt_reg - 1'b1;
        end
        if (cmd.pad_load)
        begin
            if (w_ext > t_ext)
                pad_reg <= PAD_W'(w_ext - t_ext);
            else
                pad_reg <= '0;
        end
        else if (cmd.pad_dec)
            pad_reg <= pad_reg - 1'b1;
        if (cmd.emit)
        begin
            out_char_reg <= char_sel;
            last_reg     <= cmd.last;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

    // status back to the controller
    assign st.hex         = hex_reg;
    assign st.neg         = neg_reg;
    assign st.lead_space  = !left_reg && !zf_reg;
    assign st.lead_zero   = !left_reg && zf_reg;
    assign st.trail_space = left_reg;
    assign st.conv_last   = (conv_cnt_reg == {itaf_pkg::CONV_CNT_W{1'b1}});
    assign st.norm_done   = (dig_reg[itaf_pkg::DIG_W-1 -: 4] != 4'h0) ||
                            (dig_cnt_reg == itaf_pkg::DCNT_W'(1));
    assign st.pad_zero    = (pad_reg == '0);
    assign st.pad_one     = (pad_reg == PAD_W'(1));
    assign st.dig_one     = (dig_cnt_reg == itaf_pkg::DCNT_W'(1));
    assign st.out_free    = !out_valid_reg || !out_stall;

endmodule

FILE: sv/integer_to_ascii_formatter_unit.sv
// printf-style integer field formatter, decimal or hex
// input channel: in_valid / in_stall carry one word of magnitude, sign and
//   format controls; a word is taken when in_valid is high and in_stall low
// output channel: out_valid / out_stall carry one ascii character per word,
//   last_char marks the final character of the field
// one field at a time: in_stall stays high from the cycle after the accepted
//   word until the controller is back in idle with the trailing flag clear
// decimal: the word is accepted, a shift-add-3 conversion runs over every
//   magnitude bit, leading zero digits are stripped keeping at least one,
//   the pad is sized, then one character per cycle while the output is not
//   stalled; the sign and padding steps are passed even with nothing to send
// hex: digits load directly, no conversion steps, the rest runs the same way
// with no stall the run time of a field depends on the padding, not on the
//   digit count
// a stall on the output holds the current character and pauses the emitting
//   states until the output is free; nothing is dropped
// reset clears the controller and the output valid; the block holds no state
//   between fields
module integer_to_ascii_formatter_unit #(
    parameter int MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [itaf_pkg::MAG_W-1:0]    magnitude,
    input  logic                          negative,
    input  logic                          hex_base,
    input  logic                          upper_case,
    input  logic [itaf_pkg::WIDTH_W-1:0]  min_width,
    input  logic                          zero_fill,
    input  logic                          left_align,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itaf_pkg::CHAR_W-1:0]   out_char,
    output logic                          last_char
);

    itaf_pkg::ctrl_cmd_t  cmd;
    itaf_pkg::dp_status_t st;

    // sequencer
    itaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // conversion, padding and output register
    itaf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .magnitude  (magnitude),
        .negative   (negative),
        .hex_base   (hex_base),
        .upper_case (upper_case),
        .min_width  (min_width),
        .zero_fill  (zero_fill),
        .left_align (left_align),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_char   (out_char),
        .last_char  (last_char),
        .cmd        (cmd),
        .st         (st)
    );

endmodule
